// ----- hw/rtl/ihrl_pkg.sv -----
// Package for the HEX record loader: record field phases, result and error
// codes, the result and input item structs, and the hex digit decoder.
// No dependencies; every other file of the block imports this one.
`default_nettype none

package ihrl_pkg;

  localparam int unsigned FLASH_BYTES_DEF = 32768;
  localparam logic [15:0] PROT_LIMIT_RESET = 16'h0400;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_COLON = 8'd58;

  localparam logic [7:0] REC_DATA = 8'd0;
  localparam logic [7:0] REC_EOF  = 8'd1;
  localparam logic [7:0] REC_ESA  = 8'd4;
  localparam logic [7:0] REC_ELA  = 8'd5;

  localparam logic [1:0] K_DATA = 2'd0;
  localparam logic [1:0] K_OK   = 2'd1;
  localparam logic [1:0] K_EOF  = 2'd2;
  localparam logic [1:0] K_ERR  = 2'd3;

  localparam logic [2:0] E_NO_COLON  = 3'd0;
  localparam logic [2:0] E_SHORT     = 3'd1;
  localparam logic [2:0] E_BAD_DIGIT = 3'd2;
  localparam logic [2:0] E_BAD_TYPE  = 3'd3;
  localparam logic [2:0] E_CHECKSUM  = 3'd4;
  localparam logic [2:0] E_BEYOND    = 3'd5;
  localparam logic [2:0] E_PROTECTED = 3'd6;

  typedef enum logic [6:0] {
    PH_COLON = 7'b0000001,
    PH_COUNT = 7'b0000010,
    PH_ADDR  = 7'b0000100,
    PH_TYPE  = 7'b0001000,
    PH_DATA  = 7'b0010000,
    PH_SUM   = 7'b0100000,
    PH_SKIP  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [14:0] flash_address;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
  } result_t;

  // Returns {digit_ok, value}; both letter cases are accepted.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    hex_nibble = 5'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      t = c - 8'd48;
      hex_nibble = {1'b1, t[3:0]};
    end else if (c >= 8'd65 && c <= 8'd70) begin
      t = c - 8'd55;
      hex_nibble = {1'b1, t[3:0]};
    end else if (c >= 8'd97 && c <= 8'd102) begin
      t = c - 8'd87;
      hex_nibble = {1'b1, t[3:0]};
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/intel_hex_record_loader_top.sv -----
// HEX record loader, top level: input register, record parser, result register.
// A result passes from the input register through the parser into the result register;
// one character can be taken every cycle.
// A character stalls only while the result register holds an untaken result.
// Synchronous reset clears the parser state and sets protected_limit to 0x0400.
// Depends on ihrl_pkg, ihrl_in_stage, ihrl_parser and ihrl_out_stage.
`default_nettype none

module intel_hex_record_loader_top
  import ihrl_pkg::*;
#(
  parameter int unsigned FLASH_BYTES = FLASH_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  ch,
  input  wire logic        restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [14:0]      flash_address,
  output logic [7:0]       data_byte,
  output logic [2:0]       error_code,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  in_item_t    in_item;
  in_item_t    item;
  logic        item_valid;
  logic        take;
  logic        space;
  logic        res_valid;
  result_t     res;
  result_t     res_out;
  logic [15:0] protected_limit;

  assign in_item.ch      = ch;
  assign in_item.restart = restart;

  // A character is processed only when its result, if any, has a place to go.
  assign take = item_valid && space;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      protected_limit <= PROT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      protected_limit <= cfg_data;
    end
  end

  ihrl_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ihrl_parser #(
    .FLASH_BYTES (FLASH_BYTES)
  ) u_parser (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .item            (item),
    .protected_limit (protected_limit),
    .res_valid       (res_valid),
    .res             (res)
  );

  ihrl_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .res_in    (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign kind          = res_out.kind;
  assign flash_address = res_out.flash_address;
  assign data_byte     = res_out.data_byte;
  assign error_code    = res_out.error_code;

  // Only data byte results carry an address and a byte value.
  a_data_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != K_DATA) |-> (flash_address == 15'd0 && data_byte == 8'd0))
    else $error("address or byte set on a non-data result");

  // Only error results carry an error code.
  a_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != K_ERR) |-> (error_code == 3'd0))
    else $error("error code set on a non-error result");

  // An empty input register always takes a new character.
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> in_ready)
    else $error("input stalled with an empty input register");

  // A data byte must never land below the protected limit.
  a_not_protected: assert property (@(posedge clk) disable iff (rst)
    (take && res_valid && res.kind == K_DATA) |->
      ({1'b0, res.flash_address} >= protected_limit))
    else $error("data byte emitted inside the protected area");

endmodule

`default_nettype wire

// ----- hw/rtl/ihrl_in_stage.sv -----
// Input register of the HEX record loader: holds one character until the
// parser takes it. Depends on ihrl_pkg for the input item struct.
`default_nettype none

module ihrl_in_stage
  import ihrl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     take,
  output logic          item_valid,
  output in_item_t      item
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ihrl_parser.sv -----
// Record parser of the HEX record loader: field state, running checksum,
// address base and the per-character decision. Depends on ihrl_pkg.
`default_nettype none

module ihrl_parser
  import ihrl_pkg::*;
#(
  parameter int unsigned FLASH_BYTES = FLASH_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire in_item_t    item,
  input  wire logic [15:0] protected_limit,
  output logic             res_valid,
  output result_t          res
);

  phase_t      phase,  phase_c,  phase_next;
  logic [8:0]  dcount, dcount_c, dcount_next;
  logic [7:0]  bcount, bcount_c, bcount_next;
  logic [15:0] offset, offset_c, offset_next;
  logic [7:0]  rkind,  rkind_c,  rkind_next;
  logic [7:0]  rsum,   rsum_c,   rsum_next;
  logic [31:0] base,   base_c,   base_next;
  logic [31:0] fshift, fshift_c, fshift_next;
  logic        stopped, stopped_c, stopped_next;

  logic        clr;
  logic        eol;
  logic [4:0]  hexd;
  logic [31:0] shift_v;
  logic [8:0]  dc_v;
  logic [7:0]  idx;
  logic [17:0] addr_sum;
  logic        beyond;
  logic        prot;
  logic [7:0]  sum_v;

  assign clr  = take && item.restart;
  assign eol  = (item.ch == CH_LF) || (item.ch == CH_CR);
  assign hexd = hex_nibble(item.ch);

  // A restart clears everything before the character itself is looked at.
  assign phase_c   = clr ? PH_COLON : phase;
  assign dcount_c  = clr ? 9'd0 : dcount;
  assign bcount_c  = clr ? 8'd0 : bcount;
  assign offset_c  = clr ? 16'd0 : offset;
  assign rkind_c   = clr ? 8'd0 : rkind;
  assign rsum_c    = clr ? 8'd0 : rsum;
  assign base_c    = clr ? 32'd0 : base;
  assign fshift_c  = clr ? 32'd0 : fshift;
  assign stopped_c = clr ? 1'b0 : stopped;

  assign shift_v = {fshift_c[27:0], hexd[3:0]};
  assign dc_v    = dcount_c + 9'd1;
  assign idx     = dc_v[8:1] - 8'd1;

  // The flash is at most 32 KiB, so any upper base bit is already past it.
  assign addr_sum = {2'b00, base_c[15:0]} + {2'b00, offset_c} + {10'd0, idx};
  assign beyond   = (|base_c[31:16]) || (addr_sum >= 18'(FLASH_BYTES));
  assign prot     = addr_sum < {2'b00, protected_limit};
  assign sum_v    = rsum_c + shift_v[7:0];

  always_comb begin
    phase_next   = phase_c;
    dcount_next  = dcount_c;
    bcount_next  = bcount_c;
    offset_next  = offset_c;
    rkind_next   = rkind_c;
    rsum_next    = rsum_c;
    base_next    = base_c;
    fshift_next  = fshift_c;
    stopped_next = stopped_c;
    res_valid    = 1'b0;
    res          = '0;

    if (take && !stopped_c) begin
      case (phase_c)
        PH_COLON: begin
          if (!eol) begin
            if (item.ch != CH_COLON) begin
              stopped_next   = 1'b1;
              res_valid      = 1'b1;
              res.kind       = K_ERR;
              res.error_code = E_NO_COLON;
            end else begin
              rsum_next   = 8'd0;
              phase_next  = PH_COUNT;
              dcount_next = 9'd0;
              fshift_next = 32'd0;
            end
          end
        end
        PH_SKIP: begin
          if (eol) begin
            phase_next = PH_COLON;
          end
        end
        PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_SUM: begin
          if (eol) begin
            stopped_next   = 1'b1;
            res_valid      = 1'b1;
            res.kind       = K_ERR;
            res.error_code = E_SHORT;
          end else if (!hexd[4]) begin
            stopped_next   = 1'b1;
            res_valid      = 1'b1;
            res.kind       = K_ERR;
            res.error_code = E_BAD_DIGIT;
          end else begin
            fshift_next = shift_v;
            dcount_next = dc_v;
            if (phase_c == PH_COUNT) begin
              if (dc_v == 9'd2) begin
                bcount_next = shift_v[7:0];
                rsum_next   = sum_v;
                phase_next  = PH_ADDR;
                dcount_next = 9'd0;
                fshift_next = 32'd0;
              end
            end else if (phase_c == PH_ADDR) begin
              if (dc_v == 9'd4) begin
                offset_next = shift_v[15:0];
                rsum_next   = rsum_c + shift_v[15:8] + shift_v[7:0];
                phase_next  = PH_TYPE;
                dcount_next = 9'd0;
                fshift_next = 32'd0;
              end
            end else if (phase_c == PH_TYPE) begin
              if (dc_v == 9'd2) begin
                rkind_next = shift_v[7:0];
                rsum_next  = sum_v;
                if (shift_v[7:0] == REC_EOF) begin
                  stopped_next = 1'b1;
                  res_valid    = 1'b1;
                  res.kind     = K_EOF;
                end else if (shift_v[7:0] != REC_DATA && shift_v[7:0] != REC_ESA &&
                             shift_v[7:0] != REC_ELA) begin
                  stopped_next   = 1'b1;
                  res_valid      = 1'b1;
                  res.kind       = K_ERR;
                  res.error_code = E_BAD_TYPE;
                end else begin
                  // An empty extended address record sets the base to zero.
                  if (bcount_c == 8'd0 && shift_v[7:0] != REC_DATA) begin
                    base_next = 32'd0;
                  end
                  phase_next  = (bcount_c == 8'd0) ? PH_SUM : PH_DATA;
                  dcount_next = 9'd0;
                  fshift_next = 32'd0;
                end
              end
            end else if (phase_c == PH_DATA) begin
              if (!dc_v[0]) begin
                rsum_next = sum_v;
                if (rkind_c == REC_DATA && beyond) begin
                  stopped_next   = 1'b1;
                  res_valid      = 1'b1;
                  res.kind       = K_ERR;
                  res.error_code = E_BEYOND;
                end else if (rkind_c == REC_DATA && prot) begin
                  stopped_next   = 1'b1;
                  res_valid      = 1'b1;
                  res.kind       = K_ERR;
                  res.error_code = E_PROTECTED;
                end else begin
                  if (rkind_c == REC_DATA) begin
                    res_valid         = 1'b1;
                    res.kind          = K_DATA;
                    res.flash_address = addr_sum[14:0];
                    res.data_byte     = shift_v[7:0];
                  end
                  if ({1'b0, dc_v} >= {1'b0, bcount_c, 1'b0}) begin
                    if (rkind_c == REC_ESA) begin
                      base_next = {shift_v[15:0], 16'd0};
                    end else if (rkind_c != REC_DATA) begin
                      base_next = shift_v;
                    end
                    phase_next  = PH_SUM;
                    dcount_next = 9'd0;
                    fshift_next = 32'd0;
                  end
                end
              end
            end else begin
              if (dc_v == 9'd2) begin
                rsum_next = sum_v;
                if (sum_v != 8'd0) begin
                  stopped_next   = 1'b1;
                  res_valid      = 1'b1;
                  res.kind       = K_ERR;
                  res.error_code = E_CHECKSUM;
                end else begin
                  phase_next  = PH_SKIP;
                  dcount_next = 9'd0;
                  fshift_next = 32'd0;
                  res_valid   = 1'b1;
                  res.kind    = K_OK;
                end
              end
            end
          end
        end
        default: begin
          phase_next = PH_COLON;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_COLON;
      dcount  <= 9'd0;
      bcount  <= 8'd0;
      offset  <= 16'd0;
      rkind   <= 8'd0;
      rsum    <= 8'd0;
      base    <= 32'd0;
      fshift  <= 32'd0;
      stopped <= 1'b0;
    end else begin
      phase   <= phase_next;
      dcount  <= dcount_next;
      bcount  <= bcount_next;
      offset  <= offset_next;
      rkind   <= rkind_next;
      rsum    <= rsum_next;
      base    <= base_next;
      fshift  <= fshift_next;
      stopped <= stopped_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ihrl_out_stage.sv -----
// Result register of the HEX record loader: holds one result until the
// downstream transfer. Depends on ihrl_pkg for the result struct.
`default_nettype none

module ihrl_out_stage
  import ihrl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res_in,
  output logic         space,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      res_out
);

  // The register can take a new result in the same cycle the old one leaves.
  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire
